>>> rtl/midi_controller_register_bank_defines.svh
// ----------------------------------------------------------------------------
// MIDI controller register bank: assertion macros
// Concurrent check helpers, removed when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MIDI_CONTROLLER_REGISTER_BANK_DEFINES_SVH
`define MIDI_CONTROLLER_REGISTER_BANK_DEFINES_SVH

`ifndef SYNTH
`define MCRB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define MCRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define MCRB_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define MCRB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/mcrb_pkg.sv
// ----------------------------------------------------------------------------
// MIDI controller register bank: shared package
// Depths, register indexes, request kinds and status helpers.
// ----------------------------------------------------------------------------
package mcrb_pkg;

	localparam int RX_DEPTH = 128;
	localparam int TX_DEPTH = 16;
	localparam int RX_AW    = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
	localparam int RX_CW    = $clog2(RX_DEPTH + 1);
	localparam int TX_AW    = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
	localparam int TX_CW    = $clog2(TX_DEPTH + 1);

	typedef enum logic [2:0] {
		KIND_WRITE = 3'd0,
		KIND_READ  = 3'd1,
		KIND_RX    = 3'd2,
		KIND_DRAIN = 3'd3,
		KIND_TICK  = 3'd4
	} kind_t;

	localparam logic [2:0] ADDR_VEC = 3'd0;
	localparam logic [2:0] ADDR_SEL = 3'd1;
	localparam logic [2:0] ADDR_IST = 3'd2;

	// group register index = group * 4 + (offset - 4)
	localparam logic [5:0] IDX_VEC = 6'd0;   // 0x04
	localparam logic [5:0] IDX_IEN = 6'd2;   // 0x06
	localparam logic [5:0] IDX_RSR = 6'd12;  // 0x34
	localparam logic [5:0] IDX_RDR = 6'd14;  // 0x36
	localparam logic [5:0] IDX_TSR = 6'd20;  // 0x54
	localparam logic [5:0] IDX_TDR = 6'd22;  // 0x56
	localparam logic [5:0] IDX_TCL = 6'd32;  // 0x84
	localparam logic [5:0] IDX_TCH = 6'd33;  // 0x85
	localparam logic [5:0] IDX_FF  = 6'd38;  // 0x96

	localparam logic [63:0] WRITABLE = (64'd1 << 0) | (64'd1 << 1) | (64'd1 << 2) |
		(64'd1 << 4) | (64'd1 << 5) | (64'd1 << 7) | (64'd1 << 8) | (64'd1 << 9) |
		(64'd1 << 10) | (64'd1 << 11) | (64'd1 << 13) | (64'd1 << 16) |
		(64'd1 << 17) | (64'd1 << 21) | (64'd1 << 25) | (64'd1 << 26) |
		(64'd1 << 27) | (64'd1 << 29) | (64'd1 << 30) | (64'd1 << 31) |
		(64'd1 << 32) | (64'd1 << 33) | (64'd1 << 34) | (64'd1 << 35) |
		(64'd1 << 36) | (64'd1 << 37);
	localparam logic [63:0] STORED = WRITABLE | (64'd1 << IDX_RSR) |
		(64'd1 << IDX_RDR) | (64'd1 << IDX_TSR);

	localparam logic [7:0] IRQ_RX    = 8'h20;
	localparam logic [7:0] IRQ_TX    = 8'h40;
	localparam logic [7:0] IRQ_TMR   = 8'h80;
	localparam logic [7:0] TSR_RESET = 8'hc0;
	localparam logic [7:0] FF_RESET  = 8'hff;

	function automatic logic [7:0] grp_reset(input logic [5:0] idx);
		logic [7:0] v;
		v = 8'h00;
		if (idx == IDX_TSR) v = TSR_RESET;
		if (idx == IDX_FF)  v = FF_RESET;
		return v;
	endfunction

	function automatic logic [7:0] st_build(input logic [7:0] old, input logic not_full,
		input logic not_empty);
		return {not_empty, not_full, old[5:0]};
	endfunction

	// index of lowest set bit, 8 when none
	function automatic logic [3:0] low_bit(input logic [7:0] st);
		logic [3:0] n;
		n = 4'd8;
		for (int i = 7; i >= 0; i--) begin
			if (st[i]) n = 4'(i);
		end
		return n;
	endfunction

endpackage

>>> rtl/midi_controller_register_bank.sv
// A request's result is registered into the output register when the request is accepted.
// One request per cycle while the output is not stalled; both FIFO RAMs are read ahead at the
// next head position, with a bypass when the same entry is written in that cycle.
// Reset (arst_n low): registers to defaults, FIFOs empty, timer zero, output empty.
// ----------------------------------------------------------------------------
// MIDI controller register bank
// Host bus register model with receive and transmit FIFOs, timer and IRQ.
// ----------------------------------------------------------------------------
`include "midi_controller_register_bank_defines.svh"

module midi_controller_register_bank import mcrb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] kind,
	input  logic [2:0] bus_addr,
	input  logic [7:0] bus_data,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] read_data,
	output logic       irq_n,
	output logic       tx_valid,
	output logic [7:0] tx_byte
);

	logic [7:0]       grp_q [64];
	logic [7:0]       grp_n [64];
	logic [7:0]       sel_q, sel_n, vec_q, vec_n, ist_q, ist_n;
	logic [13:0]      tmr_q, tmr_n, tmr_dec;
	logic [RX_AW-1:0] rx_head_q, rx_head_n, rx_wa, rx_ra;
	logic [RX_CW-1:0] rx_cnt_q, rx_cnt_n;
	logic [RX_CW:0]   rx_sum;
	logic [TX_AW-1:0] tx_head_q, tx_head_n, tx_wa, tx_head_nx;
	logic [TX_CW-1:0] tx_cnt_q, tx_cnt_n;
	logic [TX_CW:0]   tx_sum;
	logic             rx_we, tx_we;
	logic [7:0]       rx_rdata, tx_rdata, rx_nxt, tx_head_data;
	logic             rx_byp_q, tx_byp_q;
	logic [7:0]       rx_byp_data_q, tx_byp_data_q;
	logic             acc;
	logic [5:0]       widx;
	logic [7:0]       rd, txb, raise;
	logic             txv;
	logic             out_valid_q, irq_n_q, tx_valid_q;
	logic [7:0]       read_data_q, tx_byte_q;

	assign in_stall = out_valid_q & out_stall;
	assign acc      = in_valid & ~in_stall;
	assign widx     = {sel_q[3:0], bus_addr[1:0]};

	assign rx_sum = (RX_CW + 1)'(rx_head_q) + (RX_CW + 1)'(rx_cnt_q);
	assign rx_wa  = (rx_sum >= (RX_CW + 1)'(RX_DEPTH)) ?
		RX_AW'(rx_sum - (RX_CW + 1)'(RX_DEPTH)) : RX_AW'(rx_sum);
	assign tx_sum = (TX_CW + 1)'(tx_head_q) + (TX_CW + 1)'(tx_cnt_q);
	assign tx_wa  = (tx_sum >= (TX_CW + 1)'(TX_DEPTH)) ?
		TX_AW'(tx_sum - (TX_CW + 1)'(TX_DEPTH)) : TX_AW'(tx_sum);

	assign rx_nxt       = rx_byp_q ? rx_byp_data_q : rx_rdata;
	assign tx_head_data = tx_byp_q ? tx_byp_data_q : tx_rdata;
	assign tx_head_nx   = (tx_head_q == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_head_q + 1'b1;
	assign rx_ra        = (rx_head_n == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_head_n + 1'b1;
	assign tmr_dec      = (tmr_q != '0) ? tmr_q - 14'd1 : tmr_q;

	always_comb begin
		grp_n     = grp_q;
		sel_n     = sel_q;
		vec_n     = vec_q;
		ist_n     = ist_q;
		tmr_n     = tmr_q;
		rx_head_n = rx_head_q;
		rx_cnt_n  = rx_cnt_q;
		tx_head_n = tx_head_q;
		tx_cnt_n  = tx_cnt_q;
		rx_we     = 1'b0;
		tx_we     = 1'b0;
		rd        = 8'h00;
		txv       = 1'b0;
		txb       = 8'h00;
		raise     = 8'h00;
		if (acc) begin
			case (kind_t'(kind))
				KIND_WRITE: begin
					if (bus_addr == ADDR_SEL) begin
						sel_n = bus_data;
					end else if (bus_addr[2]) begin
						if (widx == IDX_TSR) begin
							grp_n[IDX_TSR] = st_build(grp_q[IDX_TSR],
								tx_cnt_q != TX_CW'(TX_DEPTH), tx_cnt_q != '0);
						end else if (widx == IDX_TDR) begin
							ist_n = ist_q & ~IRQ_TX;
							if (tx_cnt_q != TX_CW'(TX_DEPTH)) begin
								tx_we    = 1'b1;
								tx_cnt_n = tx_cnt_q + 1'b1;
							end
							grp_n[IDX_TSR] = st_build(grp_q[IDX_TSR],
								tx_cnt_n != TX_CW'(TX_DEPTH), tx_cnt_n != '0);
						end else if (WRITABLE[widx]) begin
							grp_n[widx] = bus_data;
							if (widx == IDX_VEC) vec_n = {bus_data[7:5], vec_q[4:0]};
							if (widx == IDX_TCH && bus_data[7])
								tmr_n = {bus_data[5:0], grp_q[IDX_TCL]};
						end
					end
				end
				KIND_READ: begin
					case (bus_addr)
						ADDR_VEC: rd = vec_q;
						ADDR_SEL: rd = sel_q;
						ADDR_IST: rd = ist_q;
						default:  rd = bus_addr[2] ? grp_q[widx] : 8'h00;
					endcase
					if (bus_addr[2]) begin
						if (widx == IDX_RSR) begin
							grp_n[IDX_RSR] = st_build(grp_q[IDX_RSR],
								rx_cnt_q != RX_CW'(RX_DEPTH), rx_cnt_q != '0);
						end else if (widx == IDX_TSR) begin
							grp_n[IDX_TSR] = st_build(grp_q[IDX_TSR],
								tx_cnt_q != TX_CW'(TX_DEPTH), tx_cnt_q != '0);
						end else if (widx == IDX_RDR && rx_cnt_q != '0) begin
							rx_head_n = (rx_head_q == RX_AW'(RX_DEPTH - 1)) ?
								'0 : rx_head_q + 1'b1;
							rx_cnt_n  = rx_cnt_q - 1'b1;
							grp_n[IDX_RSR] = st_build(grp_q[IDX_RSR], 1'b1, rx_cnt_n != '0);
							if (rx_cnt_n != '0) grp_n[IDX_RDR] = rx_nxt;
							else ist_n = ist_q & ~IRQ_RX;
						end
					end
				end
				KIND_RX: begin
					if (rx_cnt_q != RX_CW'(RX_DEPTH)) begin
						rx_we    = 1'b1;
						rx_cnt_n = rx_cnt_q + 1'b1;
						grp_n[IDX_RSR] = st_build(grp_q[IDX_RSR],
							rx_cnt_n != RX_CW'(RX_DEPTH), 1'b1);
						if (rx_cnt_q == '0) begin
							grp_n[IDX_RDR] = bus_data;
							raise = IRQ_RX;
						end
					end
				end
				KIND_DRAIN: begin
					if (tx_cnt_q != '0) begin
						txv       = 1'b1;
						txb       = tx_head_data;
						tx_head_n = tx_head_nx;
						tx_cnt_n  = tx_cnt_q - 1'b1;
						grp_n[IDX_TSR] = st_build(grp_q[IDX_TSR], 1'b1, tx_cnt_n != '0);
						if (tx_cnt_n == '0) raise = IRQ_TX;
					end
				end
				KIND_TICK: begin
					if (grp_q[IDX_IEN][7]) begin
						if (tmr_dec == '0) begin
							tmr_n = {grp_q[IDX_TCH][5:0], grp_q[IDX_TCL]};
							raise = IRQ_TMR;
						end else begin
							tmr_n = tmr_dec;
						end
					end
				end
				default: ;
			endcase
		end
		if (raise != 8'h00) begin
			ist_n = ist_n | (raise & grp_q[IDX_IEN]);
			vec_n = {grp_q[IDX_VEC][7:5], low_bit(ist_n), 1'b0};
		end
	end

	mcrb_ram #(.DEPTH(RX_DEPTH), .WIDTH(8)) u_rx_ram (
		.clk  (clk),
		.we   (rx_we),
		.waddr(rx_wa),
		.wdata(bus_data),
		.raddr(rx_ra),
		.rdata(rx_rdata)
	);

	mcrb_ram #(.DEPTH(TX_DEPTH), .WIDTH(8)) u_tx_ram (
		.clk  (clk),
		.we   (tx_we),
		.waddr(tx_wa),
		.wdata(bus_data),
		.raddr(tx_head_n),
		.rdata(tx_rdata)
	);

	// same-cycle write to the entry being prefetched
	always_ff @(posedge clk) begin
		rx_byp_data_q <= bus_data;
		tx_byp_data_q <= bus_data;
		if (acc) begin
			read_data_q <= rd;
			tx_byte_q   <= txb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 64; i++) grp_q[i] <= grp_reset(6'(i));
			sel_q       <= '0;
			vec_q       <= '0;
			ist_q       <= '0;
			tmr_q       <= '0;
			rx_head_q   <= '0;
			rx_cnt_q    <= '0;
			tx_head_q   <= '0;
			tx_cnt_q    <= '0;
			rx_byp_q    <= 1'b0;
			tx_byp_q    <= 1'b0;
			out_valid_q <= 1'b0;
			irq_n_q     <= 1'b1;
			tx_valid_q  <= 1'b0;
		end else begin
			for (int i = 0; i < 64; i++) begin
				if (STORED[i]) grp_q[i] <= grp_n[i];
			end
			sel_q     <= sel_n;
			vec_q     <= vec_n;
			ist_q     <= ist_n;
			tmr_q     <= tmr_n;
			rx_head_q <= rx_head_n;
			rx_cnt_q  <= rx_cnt_n;
			tx_head_q <= tx_head_n;
			tx_cnt_q  <= tx_cnt_n;
			rx_byp_q  <= rx_we && (rx_wa == rx_ra);
			tx_byp_q  <= tx_we && (tx_wa == tx_head_n);
			if (acc) begin
				out_valid_q <= 1'b1;
				irq_n_q     <= (ist_n == 8'h00);
				tx_valid_q  <= txv;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign irq_n     = irq_n_q;
	assign tx_valid  = tx_valid_q;
	assign tx_byte   = tx_byte_q;

	`MCRB_ASSERT_NOW(a_rx_cnt_max, clk, arst_n, 1'b1, rx_cnt_q <= RX_CW'(RX_DEPTH))
	`MCRB_ASSERT_NOW(a_tx_cnt_max, clk, arst_n, 1'b1, tx_cnt_q <= TX_CW'(TX_DEPTH))
	`MCRB_ASSERT_NOW(a_rsr_level, clk, arst_n, 1'b1, grp_q[IDX_RSR][7] == (rx_cnt_q != '0))
	`MCRB_ASSERT_NEXT(a_acc_out, clk, arst_n, acc, out_valid_q)

endmodule

>>> rtl/mcrb_ram.sv
// ----------------------------------------------------------------------------
// MIDI controller register bank: FIFO storage
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mcrb_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

>>> verif/midi_controller_register_bank_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MIDI controller register bank testbench
// Drives bus writes, bus reads, received bytes, drain events and timer ticks
// with random gaps and output stalls; a scoreboard predicts each response.
// ----------------------------------------------------------------------------
module midi_controller_register_bank_tb;
	import mcrb_pkg::*;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq_n;
		logic       tx_valid;
		logic [7:0] tx_byte;
	} resp_t;

	class bank_scoreboard;
		logic [7:0] grp[256];
		logic [7:0] dir[8];
		logic [7:0] rxq[$];
		logic [7:0] txq[$];
		int unsigned tmr;
		resp_t pending[$];
		int errors;

		function new();
			foreach (grp[i]) grp[i] = 8'h00;
			foreach (dir[i]) dir[i] = 8'h00;
			grp[8'h54] = TSR_RESET;
			grp[8'h96] = FF_RESET;
			tmr = 0;
			errors = 0;
		endfunction

		function int unsigned base();
			return {dir[1][3:0], 4'h0};
		endfunction

		function void store(int unsigned r, logic [7:0] v);
			grp[r] = v;
			if ((r & 8'hf0) == base()) dir[r & 7] = v;
		endfunction

		function void raise(logic [7:0] bits);
			int n;
			dir[2] = dir[2] | (bits & grp[8'h06]);
			for (n = 0; n < 8; n++) if (dir[2][n]) break;
			dir[0] = (grp[8'h04] & 8'he0) | 8'(n << 1);
		endfunction

		function void rx_stat();
			logic [7:0] s;
			s = grp[8'h34] & 8'h3f;
			if (rxq.size() < RX_DEPTH) s |= 8'h40;
			if (rxq.size() != 0) begin
				s |= 8'h80;
				store(8'h36, rxq[0]);
			end
			store(8'h34, s);
		endfunction

		function void tx_stat();
			logic [7:0] s;
			s = grp[8'h54] & 8'h3f;
			if (txq.size() < TX_DEPTH) s |= 8'h40;
			if (txq.size() != 0) s |= 8'h80;
			store(8'h54, s);
		endfunction

		function int unsigned count();
			return {grp[8'h85][5:0], grp[8'h84]};
		endfunction

		function bit writable(int unsigned r);
			return (r >= 4 && (r & 15) >= 4 && (r & 15) <= 7 && (r >> 4) < 10) ?
				WRITABLE[(r >> 4) * 4 + (r & 15) - 4] : 1'b0;
		endfunction

		function void note(logic [2:0] k, logic [2:0] a, logic [7:0] d);
			resp_t p;
			int unsigned r;
			p = '0;
			r = base() + a;
			case (k)
				KIND_WRITE: begin
					if (a == ADDR_SEL) begin
						dir[1] = d;
						for (int i = 4; i < 8; i++) dir[i] = grp[base() + i];
					end else if (a >= 4) begin
						if (r == 8'h54) tx_stat();
						else if (r == 8'h56) begin
							dir[2] &= ~IRQ_TX;
							if (txq.size() < TX_DEPTH) txq.push_back(d);
							tx_stat();
						end else if (writable(r)) begin
							store(r, d);
							if (r == 8'h04) dir[0] = (dir[0] & 8'h1f) | (d & 8'he0);
							if (r == 8'h85 && d[7]) tmr = count();
						end
					end
				end
				KIND_READ: begin
					p.read_data = dir[a];
					if (a >= 4) begin
						if (r == 8'h34) rx_stat();
						else if (r == 8'h54) tx_stat();
						else if (r == 8'h36 && rxq.size() != 0) begin
							void'(rxq.pop_front());
							rx_stat();
							if (!grp[8'h34][7]) dir[2] &= ~IRQ_RX;
						end
					end
				end
				KIND_RX: if (rxq.size() < RX_DEPTH) begin
					rxq.push_back(d);
					rx_stat();
					if (rxq.size() == 1) raise(IRQ_RX);
				end
				KIND_DRAIN: if (txq.size() != 0) begin
					p.tx_byte = txq.pop_front();
					p.tx_valid = 1'b1;
					tx_stat();
					if (txq.size() == 0) raise(IRQ_TX);
				end
				KIND_TICK: if (grp[8'h06][7]) begin
					if (tmr != 0) tmr--;
					if (tmr == 0) begin
						tmr = count();
						raise(IRQ_TMR);
					end
				end
				default: ;
			endcase
			p.irq_n = (dir[2] == 0);
			pending.push_back(p);
		endfunction

		function void check(resp_t got);
			resp_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected response %h", $time, got);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.read_data !== e.read_data) begin
				$display("%0t: read_data exp %h got %h", $time, e.read_data, got.read_data);
				errors++;
			end
			if (got.irq_n !== e.irq_n) begin
				$display("%0t: irq_n exp %b got %b", $time, e.irq_n, got.irq_n);
				errors++;
			end
			if (got.tx_valid !== e.tx_valid) begin
				$display("%0t: tx_valid exp %b got %b", $time, e.tx_valid, got.tx_valid);
				errors++;
			end
			if (got.tx_byte !== e.tx_byte) begin
				$display("%0t: tx_byte exp %h got %h", $time, e.tx_byte, got.tx_byte);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, in_valid, in_stall, out_valid, out_stall;
	logic [2:0] kind, bus_addr;
	logic [7:0] bus_data, read_data, tx_byte;
	logic irq_n, tx_valid;
	bank_scoreboard sb;
	bit quiet_out;

	midi_controller_register_bank dut (.*);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) sb.note(kind, bus_addr, bus_data);
		if (arst_n && out_valid && !out_stall) sb.check({read_data, irq_n, tx_valid, tx_byte});
	end

	// receiver stall pattern
	initial begin
		int w;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (out_valid && !out_stall) begin
				w = quiet_out ? 0 : $urandom_range(0, 19);
				if (($urandom & 3) == 0) w = 0;
				if (w != 0) begin
					out_stall <= 1'b1;
					repeat (w) @(negedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	task automatic send(logic [2:0] k, logic [2:0] a, logic [7:0] d, int gap);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		bus_addr <= a;
		bus_data <= d;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic int rgap();
		return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
	endfunction

	task automatic wsel(logic [3:0] g);
		send(KIND_WRITE, ADDR_SEL, {4'($urandom_range(0, 15)), g}, rgap());
	endtask

	task automatic drain_all();
		in_valid <= 1'b0;
		@(negedge clk);
		while (sb.pending.size() != 0) @(negedge clk);
	endtask

	initial begin
		logic [2:0] k;
		int n, burst;
		bit drained;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = 3'd0;
		bus_addr = 3'd0;
		bus_data = 8'd0;
		quiet_out = 1'b1;
		drained = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// directed: enable all irqs, small timer, fifo empty cases
		wsel(4'h0);
		send(KIND_WRITE, 3'd6, 8'hff, 0);
		send(KIND_WRITE, 3'd4, 8'he0, 0);
		wsel(4'h8);
		send(KIND_WRITE, 3'd4, 8'h02, 0);
		send(KIND_WRITE, 3'd5, 8'hc0, 0);
		for (int i = 0; i < 4; i++) send(KIND_TICK, 3'd0, 8'h00, 0);
		send(KIND_RX, 3'd0, 8'h00, 0);
		send(KIND_RX, 3'd0, 8'hff, 0);
		wsel(4'h3);
		send(KIND_READ, 3'd4, 8'h00, 0);
		send(KIND_READ, 3'd6, 8'h00, 0);
		send(KIND_READ, 3'd6, 8'h00, 0);
		send(KIND_READ, 3'd6, 8'h00, 0);
		send(KIND_DRAIN, 3'd0, 8'h00, 0);
		wsel(4'h5);
		send(KIND_WRITE, 3'd6, 8'ha5, 0);
		send(KIND_WRITE, 3'd4, 8'h12, 0);
		send(KIND_DRAIN, 3'd0, 8'h00, 0);
		send(KIND_READ, 3'd2, 8'h00, 0);
		send(KIND_READ, 3'd0, 8'h00, 0);
		send(3'd7, 3'd7, 8'h5a, 0);
		drain_all();
		quiet_out = 1'b0;

		// random: mostly meaningful group traffic, some bursts to fill fifos
		n = 0;
		while (n < 1900) begin
			if (n >= 900 && !drained) begin
				drain_all();
				drained = 1'b1;
			end
			if (($urandom & 63) == 0) begin
				burst = $urandom_range(1, 140);
				k = $urandom_range(0, 1) ? KIND_RX : KIND_DRAIN;
				if (k == KIND_DRAIN) begin
					wsel(4'h5);
					for (int i = 0; i < 20; i++)
						send(KIND_WRITE, 3'd6, 8'($urandom), rgap());
					n += 21;
				end else begin
					for (int i = 0; i < burst; i++) send(KIND_RX, 3'd0, 8'($urandom), 0);
					n += burst;
				end
				continue;
			end
			case ($urandom_range(0, 9))
				0: wsel(4'($urandom_range(0, 15)));
				1: wsel($urandom_range(0, 1) ? 4'h3 : 4'h5);
				2, 3: send(KIND_WRITE, 3'($urandom), 8'($urandom), rgap());
				4, 5: send(KIND_READ, 3'($urandom), 8'($urandom), rgap());
				6: send(KIND_RX, 3'($urandom), 8'($urandom), rgap());
				7: send(KIND_DRAIN, 3'($urandom), 8'($urandom), rgap());
				8: send(KIND_TICK, 3'($urandom), 8'($urandom), rgap());
				default: send(3'($urandom_range(5, 7)), 3'($urandom), 8'($urandom), rgap());
			endcase
			n++;
		end
		drain_all();
		repeat (20) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

	initial begin
		#5ms;
		$display("DONE: errors detected");
		$finish;
	end
endmodule
